// ----- design/framebuffer_to_text_renderer_macros.svh -----
// Assertion macros for the frame-to-text renderer checker.
// Expects clk and rst in the scope where a macro is used.
`ifndef FRAMEBUFFER_TO_TEXT_RENDERER_MACROS_SVH
`define FRAMEBUFFER_TO_TEXT_RENDERER_MACROS_SVH

// Same-cycle implication, off while reset is high
`define FBTR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high
`define FBTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/fbtr_pkg.sv -----
// Shared types, codes and constants for the frame-to-text renderer.
// No dependencies; imported by every module of the block.
package fbtr_pkg;

  // Request operation codes
  localparam logic [1:0] OP_STORE  = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_RENDER = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_GRAPHICS_MODE = 2'd0;
  localparam logic [1:0] CFG_FRAME_COLUMNS = 2'd1;
  localparam logic [1:0] CFG_FRAME_ROWS    = 2'd2;

  // Widths fixed by the interface
  localparam int DIM_W    = 10;  // frame and output coordinates
  localparam int QUOT_W   = 10;  // scaled source coordinate
  localparam int OFFSET_W = 21;  // byte offset into the frame (text cells are two bytes)

  // Characters
  localparam logic [6:0] CHAR_SPACE   = 7'h20;
  localparam logic [6:0] CHAR_NEWLINE = 7'd10;
  localparam logic [7:0] BYTE_PRINT_LO  = 8'h20;
  localparam logic [7:0] BYTE_PRINT_END = 8'h7F;

  // Brightness ramp " .:-=+*#%@"
  localparam int RAMP_STEPS = 10;
  localparam logic [6:0] RAMP_CHARS [RAMP_STEPS] = '{
    7'h20, 7'h2E, 7'h3A, 7'h2D, 7'h3D, 7'h2B, 7'h2A, 7'h23, 7'h25, 7'h40
  };
  // Smallest pixel value reaching each ramp step k (ceil(255*k/9)), k = 1..9
  localparam logic [7:0] RAMP_THRESH [RAMP_STEPS-1] = '{
    8'd29, 8'd57, 8'd85, 8'd114, 8'd142, 8'd170, 8'd199, 8'd227, 8'd255
  };

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_DIV_GO,
    S_DIV_WAIT,
    S_ADDR,
    S_READ,
    S_EMIT,
    S_NEWLINE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // take a request from the input channel
    logic calc;       // register grid checks and products
    logic div_start;  // launch both scale dividers
    logic addr;       // register the frame offset
    logic read;       // read the frame store
    logic emit_char;  // load the character result
    logic emit_nl;    // load the end-of-row result
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic op_render;  // request on the input port is a render
    logic gfx;        // graphics mode
    logic in_grid;    // captured position lies inside the output grid
    logic newline;    // captured position is the last column of its row
    logic div_busy;   // a divider is still iterating
    logic out_free;   // output register can take a result this cycle
  } ctrl_status_t;

  // Map a pixel value to its ramp character, index (v*9)/255
  function automatic logic [6:0] ramp_char(input logic [7:0] v);
    logic [3:0] idx;
    idx = 4'd0;
    for (int k = 0; k < RAMP_STEPS - 1; k++) begin
      if (v >= RAMP_THRESH[k]) begin
        idx = 4'(k + 1);
      end
    end
    return RAMP_CHARS[idx];
  endfunction

endpackage

// ----- design/fbtr_div.sv -----
// Restoring divider, one quotient bit per cycle, for the nearest-neighbor scale.
// Depends on fbtr_pkg; the quotient must be known to fit in QW bits.
module fbtr_div import fbtr_pkg::*; #(
  parameter int NW = 17,
  parameter int DW = 8,
  parameter int QW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [QW-1:0] quot
);

  localparam int CNT_W = $clog2(QW + 1);

  logic [DW-1:0]    rem;
  logic [QW-1:0]    q;
  logic [CNT_W-1:0] cnt;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_next;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial    = {rem, q[QW-1]};
    diff     = trial - {1'b0, den};
    ge       = trial >= {1'b0, den};
    rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  // Control: count the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(QW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: high part of the dividend starts as remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DW'(num[NW-1:QW]);
      q   <= num[QW-1:0];
    end else if (busy) begin
      rem <= rem_next;
      q   <= {q[QW-2:0], ge};
    end
  end

  assign quot = q;

endmodule

// ----- design/fbtr_ctrl.sv -----
// Controller state machine: sequences capture, scaling, address, read and emit.
// Depends on fbtr_pkg for state_t, ctrl_cmd_t and ctrl_status_t.
module fbtr_ctrl import fbtr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = rst || (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid && !rst) begin
          cmd.capture = 1'b1;
          if (status.op_render) begin
            state_next = S_CALC;
          end
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        if (!status.in_grid) begin
          state_next = S_IDLE;
        end else if (status.gfx) begin
          state_next = S_DIV_GO;
        end else begin
          state_next = S_ADDR;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!status.div_busy) begin
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit_char = 1'b1;
          state_next    = status.newline ? S_NEWLINE : S_IDLE;
        end
      end
      S_NEWLINE: begin
        if (status.out_free) begin
          cmd.emit_nl = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/fbtr_dp.sv -----
// Datapath: configuration, frame store and length, grid math, scale dividers,
// character mapping and output register. Depends on fbtr_pkg and fbtr_div.
module fbtr_dp import fbtr_pkg::*; #(
  parameter int FRAME_BYTES  = 65536,
  parameter int MAX_OUT_COLS = 80,
  parameter int MAX_OUT_ROWS = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  ctrl_cmd_t        cmd,
  output ctrl_status_t     status,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  input  logic [1:0]       operation,
  input  logic             frame_first,
  input  logic [7:0]       frame_byte,
  input  logic [DIM_W-1:0] out_row,
  input  logic [DIM_W-1:0] out_col,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [6:0]       char_code,
  output logic             last
);

  localparam int AW  = $clog2(FRAME_BYTES);
  localparam int LW  = $clog2(FRAME_BYTES + 1);
  localparam int CCW = $clog2(MAX_OUT_COLS);
  localparam int CDW = $clog2(MAX_OUT_COLS + 1);
  localparam int RCW = $clog2(MAX_OUT_ROWS);
  localparam int RDW = $clog2(MAX_OUT_ROWS + 1);
  localparam int CNW = CCW + DIM_W;
  localparam int RNW = RCW + DIM_W;
  localparam int PW  = 2 * DIM_W;
  localparam logic [DIM_W-1:0] MAX_COLS_D = DIM_W'(MAX_OUT_COLS);
  localparam logic [DIM_W-1:0] MAX_ROWS_D = DIM_W'(MAX_OUT_ROWS);
  localparam logic [LW-1:0]    FULL_LEN   = LW'(FRAME_BYTES);

  // Configuration
  logic             graphics_mode;
  logic [DIM_W-1:0] frame_columns;
  logic [DIM_W-1:0] frame_rows;

  // Frame store
  logic [7:0]    mem [FRAME_BYTES];
  logic [LW-1:0] frame_length;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  // Request and intermediate registers
  logic [DIM_W-1:0]  req_row;
  logic [DIM_W-1:0]  req_col;
  logic [PW-1:0]     prod_a;
  logic [CNW-1:0]    prod_b;
  logic [CDW-1:0]    grid_cols_q;
  logic [RDW-1:0]    grid_rows_q;
  logic              newline;
  logic [OFFSET_W-1:0] offset;
  logic [7:0]        rd_data;
  logic              hit;

  // Combinational helpers
  logic [DIM_W-1:0]    gfx_cols;
  logic [DIM_W-1:0]    gfx_rows;
  logic [DIM_W-1:0]    grid_cols;
  logic [DIM_W-1:0]    grid_rows;
  logic                in_grid;
  logic [PW-1:0]       prod_a_next;
  logic [PW-1:0]       prod_b_full;
  logic [QUOT_W-1:0]   sx;
  logic [QUOT_W-1:0]   sy;
  logic                busy_x;
  logic                busy_y;
  logic [PW-1:0]       text_cell;
  logic [OFFSET_W-1:0] offset_next;
  logic [7:0]          pixel;
  logic [6:0]          text_char;
  logic [6:0]          shown_char;
  logic                out_free;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      graphics_mode <= 1'b0;
      frame_columns <= '0;
      frame_rows    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRAPHICS_MODE: graphics_mode <= cfg_data[0];
        CFG_FRAME_COLUMNS: frame_columns <= cfg_data;
        CFG_FRAME_ROWS:    frame_rows    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Append a stored byte; a first byte restarts the frame, a full frame drops it
  assign wr_en   = cmd.capture && (operation == OP_STORE) &&
                   (frame_first || (frame_length != FULL_LEN));
  assign wr_addr = frame_first ? '0 : frame_length[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= '0;
    end else if (cmd.capture) begin
      case (operation)
        OP_STORE: begin
          if (frame_first) begin
            frame_length <= LW'(1);
          end else if (frame_length != FULL_LEN) begin
            frame_length <= frame_length + 1'b1;
          end
        end
        OP_CLEAR: frame_length <= '0;
        default: begin
        end
      endcase
    end
  end

  // Frame memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= frame_byte;
    end
    if (cmd.read) begin
      rd_data <= mem[offset[AW-1:0]];
    end
  end

  // Hold the render position
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_row <= out_row;
      req_col <= out_col;
    end
  end

  // Grid bounds, in-grid check and the products for offset and scale
  always_comb begin
    gfx_cols    = (frame_columns < MAX_COLS_D) ? frame_columns : MAX_COLS_D;
    gfx_rows    = (frame_rows < MAX_ROWS_D) ? frame_rows : MAX_ROWS_D;
    grid_cols   = graphics_mode ? gfx_cols : frame_columns;
    grid_rows   = graphics_mode ? gfx_rows : frame_rows;
    in_grid     = (req_row < grid_rows) && (req_col < grid_cols);
    prod_a_next = PW'(req_row) * PW'(graphics_mode ? frame_rows : frame_columns);
    prod_b_full = PW'(req_col) * PW'(frame_columns);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      prod_a      <= prod_a_next;
      prod_b      <= prod_b_full[CNW-1:0];
      grid_cols_q <= gfx_cols[CDW-1:0];
      grid_rows_q <= gfx_rows[RDW-1:0];
      newline     <= ({1'b0, req_col} + 1'b1) == {1'b0, grid_cols};
    end
  end

  // Source column and row: col*frame_columns/grid_cols, row*frame_rows/grid_rows
  fbtr_div #(.NW(CNW), .DW(CDW), .QW(QUOT_W)) u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (prod_b),
    .den   (grid_cols_q),
    .busy  (busy_x),
    .quot  (sx)
  );

  fbtr_div #(.NW(RNW), .DW(RDW), .QW(QUOT_W)) u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (prod_a[RNW-1:0]),
    .den   (grid_rows_q),
    .busy  (busy_y),
    .quot  (sy)
  );

  // Byte offset: pixel sy*columns+sx, or the character byte of a text cell
  always_comb begin
    text_cell = prod_a + PW'(req_col);
    if (graphics_mode) begin
      offset_next = OFFSET_W'(PW'(sy) * PW'(frame_columns)) + OFFSET_W'(sx);
    end else begin
      offset_next = {text_cell, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.addr) begin
      offset <= offset_next;
    end
    if (cmd.read) begin
      hit <= offset < OFFSET_W'(frame_length);
    end
  end

  // Map the byte read to a printable character
  always_comb begin
    pixel = hit ? rd_data : 8'd0;
    if (hit && (rd_data >= BYTE_PRINT_LO) && (rd_data < BYTE_PRINT_END)) begin
      text_char = rd_data[6:0];
    end else begin
      text_char = CHAR_SPACE;
    end
    shown_char = graphics_mode ? ramp_char(pixel) : text_char;
  end

  // Output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_char || cmd.emit_nl) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_char) begin
      char_code <= shown_char;
      last      <= !newline;
    end else if (cmd.emit_nl) begin
      char_code <= CHAR_NEWLINE;
      last      <= 1'b1;
    end
  end

  // Status toward the controller
  always_comb begin
    status.op_render = (operation == OP_RENDER);
    status.gfx       = graphics_mode;
    status.in_grid   = in_grid;
    status.newline   = newline;
    status.div_busy  = busy_x || busy_y;
    status.out_free  = out_free;
  end

endmodule

// ----- design/framebuffer_to_text_renderer.sv -----
// Frame-to-text renderer: keeps a byte frame store and renders one text position
// per render request, as a cell character (text mode) or a ramp character of a
// nearest-neighbor downscaled pixel (graphics mode).
// Input channel (in_valid/in_stall): store a byte, clear the frame or render a
// position. Store and clear produce no result; a render inside the grid gives
// one character, plus a newline (10) with last=1 after the last column.
// Output channel (out_valid/out_stall): one registered result; it holds while
// out_stall is high, and the next request is accepted while it waits.
// Config channel (cfg_valid/cfg_ready): index 0 graphics_mode, 1 frame_columns,
// 2 frame_rows; write only while the block is idle.
// Sequence: store and clear are done on acceptance. A text render passes CALC,
// ADDR, READ and EMIT; a graphics render adds DIV_GO and DIV_WAIT, where the two
// 10-step scale dividers run. One request is in flight at a time, so the next one
// is accepted once the last result has entered the output register.
// Reset (rst, synchronous): empties the frame, zeroes the config registers
// and drops any pending result; the frame store contents are left as they are.
module framebuffer_to_text_renderer import fbtr_pkg::*; #(
  parameter int FRAME_BYTES  = 65536,
  parameter int MAX_OUT_COLS = 80,
  parameter int MAX_OUT_ROWS = 40
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       operation,
  input  logic             frame_first,
  input  logic [7:0]       frame_byte,
  input  logic [DIM_W-1:0] out_row,
  input  logic [DIM_W-1:0] out_col,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [6:0]       char_code,
  output logic             last,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Accept register writes whenever out of reset
  assign cfg_ready = !rst;

  fbtr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  fbtr_dp #(
    .FRAME_BYTES  (FRAME_BYTES),
    .MAX_OUT_COLS (MAX_OUT_COLS),
    .MAX_OUT_ROWS (MAX_OUT_ROWS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .operation   (operation),
    .frame_first (frame_first),
    .frame_byte  (frame_byte),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .char_code   (char_code),
    .last        (last)
  );

endmodule

// ----- design/fbtr_checker.sv -----
// Port-level checker for the frame-to-text renderer, bound to the top level.
// Depends on fbtr_pkg and framebuffer_to_text_renderer_macros.svh.
`include "framebuffer_to_text_renderer_macros.svh"

module fbtr_checker import fbtr_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] operation,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] char_code,
  input logic       last
);

  // A stalled result holds
  `FBTR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(char_code) && $stable(last), "stalled result changed")

  // A character that is not last is followed at once by the newline
  `FBTR_ASSERT_NEXT(a_nl_follows, out_valid && !out_stall && !last, out_valid && last && (char_code == CHAR_NEWLINE), "newline did not follow")

  // A newline always closes its request
  `FBTR_ASSERT_NOW(a_nl_last, out_valid && (char_code == CHAR_NEWLINE), last, "newline without last")

  // No new request while the newline of the current one is still owed
  `FBTR_ASSERT_NOW(a_busy_nl, out_valid && !last, in_stall, "request taken before newline")

  // Store, clear and unused codes make no result
  `FBTR_ASSERT_NEXT(a_no_result, in_valid && !in_stall && (operation != OP_RENDER) && !out_valid, !out_valid, "result from a non-render request")

endmodule

bind framebuffer_to_text_renderer fbtr_checker u_checker (.*);
